[hw/rtl/sisl_pkg.sv]
// shared types and codes for the sorted identifier slot lookup
`default_nettype none
package sisl_pkg;

   localparam int unsigned KEY_W = 64;
   localparam int unsigned SLOT_W = 10;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NONE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ORDER = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL = 3'd4;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [KEY_W-1:0]    key;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_item_type;

endpackage
`default_nettype wire

[hw/rtl/sisl_id_ram.sv]
// identifier table memory, one write port and one registered read port
`default_nettype none
module sisl_id_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/sorted_id_slot_lookup_top.sv]
// top level: sorted identifier table with dense fast path and binary search
// clear, append, no-op, none lookups and lookups on a contiguous run: the result
// strobes in the cycle after the item is taken and busy stays low, one item per cycle
// other lookups: a binary search with one table probe per cycle, then one equality
// check of the lower bound; the result strobes in the first idle cycle
// synchronous reset empties the table; the table memory itself is not cleared
// the receiver cannot stall, so each result shows for exactly one cycle
`default_nettype none
module sorted_id_slot_lookup_top
   import sisl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_item_type     req_item,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   input  wire logic             csr_we,
   input  wire logic [KEY_W-1:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_CHECK  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [KEY_W-1:0]   first_ff, first_in;
   logic [KEY_W-1:0]   last_ff, last_in;
   logic               contig_ff, contig_in;
   logic [KEY_W-1:0]   none_ff, none_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               accept;
   logic               wr_en;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KEY_W-1:0]   rd_data;
   logic [KEY_W-1:0]   offset;
   logic               less;
   logic [CNT_W-1:0]   lo_next;
   logic [CNT_W-1:0]   hi_next;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   assign offset = req_item.key - first_ff;

   // one probe a cycle: the entry at mid is on rd_data
   assign less = (rd_data < key_ff);
   assign lo_next = less ? (mid_ff + CNT_W'(1)) : lo_ff;
   assign hi_next = less ? hi_ff : mid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      first_in = first_ff;
      last_in = last_ff;
      contig_in = contig_ff;
      none_in = csr_we ? csr_wdata : none_ff;
      key_in = key_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      rd_addr = mid_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in.status = STAT_OK;
               rsp_item_in.slot = '0;
               case (req_item.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     first_in = '0;
                     last_in = '0;
                     contig_in = 1'b1;
                  end
                  OP_APPEND: begin
                     if (req_item.key == none_ff) begin
                        rsp_item_in.status = STAT_NONE;
                     end else if ((count_ff != '0) && (req_item.key <= last_ff)) begin
                        rsp_item_in.status = STAT_ORDER;
                     end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_item_in.status = STAT_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (count_ff == '0) begin
                           first_in = req_item.key;
                        end else if (req_item.key != (last_ff + KEY_W'(1))) begin
                           contig_in = 1'b0;
                        end
                        last_in = req_item.key;
                        count_in = count_ff + CNT_W'(1);
                        rsp_item_in.slot = SLOT_W'(count_ff);
                     end
                  end
                  OP_LOOKUP: begin
                     if (req_item.key == none_ff) begin
                        rsp_item_in.status = STAT_NONE;
                     end else if (contig_ff) begin
                        if ((req_item.key < first_ff) || (offset >= KEY_W'(count_ff))) begin
                           rsp_item_in.status = STAT_NOT_FOUND;
                        end else begin
                           rsp_item_in.slot = SLOT_W'(offset);
                        end
                     end else if (count_ff == '0) begin
                        rsp_item_in.status = STAT_NOT_FOUND;
                     end else begin
                        // start the search, first probe at the middle
                        rsp_strobe_in = 1'b0;
                        key_in = req_item.key;
                        lo_in = '0;
                        hi_in = count_ff;
                        mid_in = count_ff >> 1;
                        rd_en = 1'b1;
                        rd_addr = mid_in[ADDR_W-1:0];
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (lo_next < hi_next) begin
               mid_in = lo_next + ((hi_next - lo_next) >> 1);
               rd_en = 1'b1;
               rd_addr = mid_in[ADDR_W-1:0];
            end else if (lo_next >= count_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in.status = STAT_NOT_FOUND;
               rsp_item_in.slot = '0;
               state_in = S_IDLE;
            end else begin
               // lower bound found, read it back for the equality check
               rd_en = 1'b1;
               rd_addr = lo_next[ADDR_W-1:0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rsp_strobe_in = 1'b1;
            if (rd_data == key_ff) begin
               rsp_item_in.status = STAT_OK;
               rsp_item_in.slot = SLOT_W'(lo_ff);
            end else begin
               rsp_item_in.status = STAT_NOT_FOUND;
               rsp_item_in.slot = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         first_ff <= '0;
         last_ff <= '0;
         contig_ff <= 1'b1;
         none_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         first_ff <= first_in;
         last_ff <= last_in;
         contig_ff <= contig_in;
         none_ff <= none_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      rsp_item_ff <= rsp_item_in;
   end

   sisl_id_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (KEY_W)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_item.key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

[hw/rtl/sisl_checker.sv]
// port level checks for the sorted identifier slot lookup, bound to the top level
`default_nettype none
module sisl_checker
   import sisl_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire req_item_type     req_item,
   input wire logic             rsp_strobe,
   input wire rsp_item_type     rsp_item
);

   // a failed item never reports a slot
   a_slot_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != STAT_OK)) |-> (rsp_item.slot == '0))
      else $error("slot nonzero with error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.status <= STAT_FULL))
      else $error("status code out of range");

   // everything but a lookup answers in the next cycle
   a_fast_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.opcode != OP_LOOKUP)) |=> (rsp_strobe && !busy))
      else $error("non-lookup item did not answer next cycle");

   // an accepted item either answers at once or starts a search
   a_lookup_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe != busy))
      else $error("accepted item neither answered nor searching");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

endmodule

bind sorted_id_slot_lookup_top sisl_checker u_sisl_checker (.*);
`default_nettype wire
